// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion shorthands for the screen engine RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define TESC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define TESC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/tesc_pkg.sv =====
// ----------------------------------------------------------------------------
// tesc_pkg
// Shared types, character codes and command/status structs of the engine.
// ----------------------------------------------------------------------------
package tesc_pkg;

    // character codes
    localparam logic [6:0] CH_SPACE = 7'h20;
    localparam logic [6:0] CH_DEL   = 7'h7F;
    localparam logic [6:0] CH_BS    = 7'h08;
    localparam logic [6:0] CH_HT    = 7'h09;
    localparam logic [6:0] CH_LF    = 7'h0A;
    localparam logic [6:0] CH_CR    = 7'h0D;
    localparam logic [6:0] CH_SO    = 7'h0E;
    localparam logic [6:0] CH_ESC   = 7'h1B;
    localparam logic [6:0] CH_SLASH = 7'h2F;
    localparam logic [6:0] CH_H     = 7'h48;

    // escape command characters
    localparam logic [6:0] EC_UP       = 7'h41;
    localparam logic [6:0] EC_DOWN     = 7'h42;
    localparam logic [6:0] EC_RIGHT    = 7'h43;
    localparam logic [6:0] EC_LEFT     = 7'h44;
    localparam logic [6:0] EC_HOME     = 7'h48;
    localparam logic [6:0] EC_ERASE_SC = 7'h4A;
    localparam logic [6:0] EC_ERASE_LN = 7'h4B;
    localparam logic [6:0] EC_ADDR     = 7'h59;
    localparam logic [6:0] EC_IDENT    = 7'h5A;
    localparam logic [6:0] EC_HOLD_ON  = 7'h5B;
    localparam logic [6:0] EC_HOLD_OFF = 7'h5C;

    localparam logic [7:0] TAB_LAST_STOP = 8'd72;

    // direct addressing phase
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_ROW  = 2'd1;
    localparam logic [1:0] PH_COL  = 2'd2;

    localparam logic [1:0] REPLY_LAST = 2'd2;

    typedef enum logic [4:0] {
        ACT_NONE,
        ACT_UP,
        ACT_DOWN,
        ACT_RIGHT,
        ACT_LEFT,
        ACT_HOME,
        ACT_ERASE_LINE,
        ACT_ERASE_SCREEN,
        ACT_HOLD_ON,
        ACT_HOLD_OFF,
        ACT_PRINT,
        ACT_TAB,
        ACT_LF,
        ACT_CR,
        ACT_BS,
        ACT_ADDR_ROW,
        ACT_ADDR_COL,
        ACT_READ
    } t_act;

    typedef struct packed {
        logic       load;
        logic       exec;
        t_act       act;
        logic       blank_step;
        logic       copy_step;
        logic       bottom_load;
        logic       read_take;
        logic       reply_on;
        logic [1:0] reply_idx;
    } t_cmd;

    typedef struct packed {
        logic blank_last;
        logic copy_last;
        logic at_bottom;
    } t_stat;

    function automatic logic [6:0] reply_char(input logic [1:0] idx);
        logic [6:0] c;
        unique case (idx)
            2'd0:    c = CH_ESC;
            2'd1:    c = CH_SLASH;
            default: c = CH_H;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/tesc_ctrl.sv =====
// ----------------------------------------------------------------------------
// tesc_ctrl
// Sequencer: accepts words, decodes escape/addressing, drives the datapath.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tesc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic             i_op,
    input  logic [6:0]       i_char_in,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    input  tesc_pkg::t_stat  i_stat,
    output tesc_pkg::t_cmd   o_cmd
);

    typedef enum logic [7:0] {
        S_CLEAR  = 8'b0000_0001,
        S_IDLE   = 8'b0000_0010,
        S_EXEC   = 8'b0000_0100,
        S_READ   = 8'b0000_1000,
        S_SCROLL = 8'b0001_0000,
        S_TAIL   = 8'b0010_0000,
        S_BLANK  = 8'b0100_0000,
        S_RESULT = 8'b1000_0000
    } t_state;

    t_state         r_state, n_state;
    logic           r_op;
    logic [6:0]     r_char;
    logic           r_esc, n_esc;
    logic [1:0]     r_phase, n_phase;
    logic           r_reply;
    logic [1:0]     r_ridx;
    tesc_pkg::t_act w_act;
    logic           w_ident;
    logic           w_load;
    logic           w_take;

    assign w_load = (r_state == S_IDLE) && i_in_valid;
    assign w_take = (r_state == S_RESULT) && !i_out_stall;

    // decode the captured word against the escape/addressing phase
    always_comb begin
        w_act   = tesc_pkg::ACT_NONE;
        n_esc   = r_esc;
        n_phase = r_phase;
        w_ident = 1'b0;
        if (r_op) begin
            w_act = tesc_pkg::ACT_READ;
        end else if (r_phase == tesc_pkg::PH_ROW) begin
            w_act   = tesc_pkg::ACT_ADDR_ROW;
            n_phase = tesc_pkg::PH_COL;
        end else if (r_phase != tesc_pkg::PH_IDLE) begin
            w_act   = tesc_pkg::ACT_ADDR_COL;
            n_phase = tesc_pkg::PH_IDLE;
        end else if (r_esc) begin
            n_esc = 1'b0;
            unique case (r_char)
                tesc_pkg::EC_UP:       w_act = tesc_pkg::ACT_UP;
                tesc_pkg::EC_DOWN:     w_act = tesc_pkg::ACT_DOWN;
                tesc_pkg::EC_RIGHT:    w_act = tesc_pkg::ACT_RIGHT;
                tesc_pkg::EC_LEFT:     w_act = tesc_pkg::ACT_LEFT;
                tesc_pkg::EC_HOME:     w_act = tesc_pkg::ACT_HOME;
                tesc_pkg::EC_ERASE_LN: w_act = tesc_pkg::ACT_ERASE_LINE;
                tesc_pkg::EC_ERASE_SC: w_act = tesc_pkg::ACT_ERASE_SCREEN;
                tesc_pkg::EC_ADDR:     n_phase = tesc_pkg::PH_ROW;
                tesc_pkg::EC_IDENT:    w_ident = 1'b1;
                tesc_pkg::EC_HOLD_ON:  w_act = tesc_pkg::ACT_HOLD_ON;
                tesc_pkg::EC_HOLD_OFF: w_act = tesc_pkg::ACT_HOLD_OFF;
                default:               w_act = tesc_pkg::ACT_NONE;
            endcase
        end else if (r_char >= tesc_pkg::CH_SPACE) begin
            if (r_char != tesc_pkg::CH_DEL) begin
                w_act = tesc_pkg::ACT_PRINT;
            end
        end else begin
            unique case (r_char)
                tesc_pkg::CH_HT:  w_act = tesc_pkg::ACT_TAB;
                tesc_pkg::CH_LF:  w_act = tesc_pkg::ACT_LF;
                tesc_pkg::CH_CR:  w_act = tesc_pkg::ACT_CR;
                tesc_pkg::CH_SO:  n_phase = tesc_pkg::PH_ROW;
                tesc_pkg::CH_BS:  w_act = tesc_pkg::ACT_BS;
                tesc_pkg::CH_ESC: n_esc = 1'b1;
                default:          w_act = tesc_pkg::ACT_NONE;
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_stat.blank_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                priority if (w_act == tesc_pkg::ACT_READ) begin
                    n_state = S_READ;
                end else if (w_act == tesc_pkg::ACT_LF && i_stat.at_bottom) begin
                    n_state = S_SCROLL;
                end else if (w_act == tesc_pkg::ACT_ERASE_LINE ||
                             w_act == tesc_pkg::ACT_ERASE_SCREEN) begin
                    n_state = S_BLANK;
                end else begin
                    n_state = S_RESULT;
                end
            end
            S_READ:   n_state = S_RESULT;
            S_SCROLL: begin
                if (i_stat.copy_last) n_state = S_TAIL;
            end
            S_TAIL:   n_state = S_BLANK;
            S_BLANK: begin
                if (i_stat.blank_last) n_state = S_RESULT;
            end
            S_RESULT: begin
                if (w_take && !(r_reply && r_ridx != tesc_pkg::REPLY_LAST)) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_esc   <= 1'b0;
            r_phase <= tesc_pkg::PH_IDLE;
            r_reply <= 1'b0;
            r_ridx  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_EXEC) begin
                r_esc   <= n_esc;
                r_phase <= n_phase;
                r_reply <= w_ident;
                r_ridx  <= '0;
            end else if (w_take) begin
                // advance through the reply bytes, drop the reply when done
                if (r_reply && r_ridx != tesc_pkg::REPLY_LAST) begin
                    r_ridx <= r_ridx + 2'd1;
                end else begin
                    r_reply <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_op   <= i_op;
            r_char <= i_char_in;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_RESULT);

    always_comb begin
        o_cmd             = '0;
        o_cmd.load        = w_load;
        o_cmd.exec        = (r_state == S_EXEC);
        o_cmd.act         = (r_state == S_EXEC) ? w_act : tesc_pkg::ACT_NONE;
        o_cmd.blank_step  = (r_state == S_CLEAR) || (r_state == S_BLANK);
        o_cmd.copy_step   = (r_state == S_SCROLL);
        o_cmd.bottom_load = (r_state == S_TAIL);
        o_cmd.read_take   = (r_state == S_READ);
        o_cmd.reply_on    = r_reply;
        o_cmd.reply_idx   = r_ridx;
    end

    `TESC_ASSERT_IMP(a_ridx_range, i_clk, i_rst_n, 1'b1, r_ridx <= tesc_pkg::REPLY_LAST)
    `TESC_ASSERT_IMP(a_reply_clean, i_clk, i_rst_n, r_reply, !r_esc && r_phase == tesc_pkg::PH_IDLE)
    `TESC_ASSERT_NXT(a_lf_no_scroll, i_clk, i_rst_n, r_state == S_EXEC && w_act == tesc_pkg::ACT_LF && !i_stat.at_bottom, r_state == S_RESULT)
    `TESC_ASSERT_NXT(a_stall_keeps, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(r_ridx))

endmodule

// ===== rtl/tesc_dpath.sv =====
// ----------------------------------------------------------------------------
// tesc_dpath
// Cursor, hold flag, screen store with sweep/scroll pointers and result word.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tesc_dpath #(
    parameter int COLS = 80,
    parameter int ROWS = 12
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tesc_pkg::t_cmd   i_cmd,
    output tesc_pkg::t_stat  o_stat,
    input  logic [6:0]       i_char_in,
    input  logic [3:0]       i_read_row,
    input  logic [6:0]       i_read_col,
    output logic [6:0]       o_cursor_col,
    output logic [3:0]       o_cursor_row,
    output logic             o_hold_mode,
    output logic             o_reply_valid,
    output logic [6:0]       o_reply_byte,
    output logic [6:0]       o_cell_char,
    output logic             o_last
);

    localparam int CW    = $clog2(COLS);
    localparam int RW    = $clog2(ROWS);
    localparam int DEPTH = ROWS * COLS;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = AW + 1;
    localparam logic [CW-1:0] LAST_COL = CW'(COLS - 1);
    localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);

    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;
    logic          r_hold, n_hold;
    logic [7:0]    r_arow, n_arow;
    logic [6:0]    r_char;
    logic [3:0]    r_rrow;
    logic [6:0]    r_rcol;
    logic          r_in_range;
    logic [6:0]    r_cell;
    logic [PW-1:0] r_ptr;
    logic [PW-1:0] r_end;
    logic          r_cp_pend;
    logic [AW-1:0] r_cp_addr;
    logic [6:0]    r_rdata;
    logic [6:0]    r_mem [0:DEPTH-1];

    logic [AW-1:0] w_cur_addr;
    logic [PW-1:0] w_row_end;
    logic          w_in_range;
    logic [AW-1:0] w_rd_addr;
    logic [6:0]    w_fold;
    logic [7:0]    w_c8;
    logic [7:0]    w_tab;
    logic [7:0]    w_tab_cl;
    logic [6:0]    w_acol;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [6:0]    w_wdata;
    logic          w_re;
    logic [AW-1:0] w_raddr;

    assign w_cur_addr = AW'(r_row * COLS + r_col);
    assign w_row_end  = PW'((r_row + 1) * COLS);
    assign w_in_range = (r_rrow < ROWS) && (r_rcol < COLS);
    assign w_rd_addr  = w_in_range ? AW'(r_rrow * COLS + r_rcol) : '0;

    assign w_fold   = (r_char >= 7'h40) ? (r_char & ~7'h20) : r_char;
    assign w_c8     = 8'(r_col);
    assign w_tab    = (w_c8 >= tesc_pkg::TAB_LAST_STOP) ? (w_c8 + 8'd1)
                                                        : ((w_c8 + 8'd8) & 8'hF8);
    assign w_tab_cl = (w_tab > 8'(COLS - 1)) ? 8'(COLS - 1) : w_tab;
    assign w_acol   = r_char - tesc_pkg::CH_SPACE;

    always_comb begin
        n_col  = r_col;
        n_row  = r_row;
        n_hold = r_hold;
        n_arow = r_arow;
        if (i_cmd.exec) begin
            unique case (i_cmd.act)
                tesc_pkg::ACT_UP: begin
                    if (r_row != '0) n_row = r_row - 1'b1;
                end
                tesc_pkg::ACT_DOWN, tesc_pkg::ACT_LF: begin
                    if (r_row != LAST_ROW) n_row = r_row + 1'b1;
                end
                tesc_pkg::ACT_RIGHT, tesc_pkg::ACT_PRINT: begin
                    if (r_col != LAST_COL) n_col = r_col + 1'b1;
                end
                tesc_pkg::ACT_LEFT, tesc_pkg::ACT_BS: begin
                    if (r_col != '0) n_col = r_col - 1'b1;
                end
                tesc_pkg::ACT_HOME: begin
                    n_col = '0;
                    n_row = '0;
                end
                tesc_pkg::ACT_HOLD_ON:  n_hold = 1'b1;
                tesc_pkg::ACT_HOLD_OFF: n_hold = 1'b0;
                tesc_pkg::ACT_TAB:      n_col = CW'(w_tab_cl);
                tesc_pkg::ACT_CR:       n_col = '0;
                tesc_pkg::ACT_ADDR_ROW: n_arow = 8'(r_char) - 8'(tesc_pkg::CH_SPACE);
                tesc_pkg::ACT_ADDR_COL: begin
                    // negative rows (as a signed byte) land on the bottom too
                    n_row = (r_arow < 8'(ROWS)) ? RW'(r_arow) : LAST_ROW;
                    if (r_char < tesc_pkg::CH_SPACE) begin
                        n_col = '0;
                    end else if (8'(w_acol) > 8'(COLS - 1)) begin
                        n_col = LAST_COL;
                    end else begin
                        n_col = CW'(w_acol);
                    end
                end
                default: ;
            endcase
        end
    end

    // write port: scroll copy, then blanking sweep, then printing
    always_comb begin
        w_we    = 1'b0;
        w_waddr = w_cur_addr;
        w_wdata = w_fold;
        priority if (r_cp_pend) begin
            w_we    = 1'b1;
            w_waddr = r_cp_addr;
            w_wdata = r_rdata;
        end else if (i_cmd.blank_step) begin
            w_we    = 1'b1;
            w_waddr = r_ptr[AW-1:0];
            w_wdata = tesc_pkg::CH_SPACE;
        end else if (i_cmd.exec && i_cmd.act == tesc_pkg::ACT_PRINT) begin
            w_we = 1'b1;
        end
    end

    assign w_re    = i_cmd.copy_step || (i_cmd.exec && i_cmd.act == tesc_pkg::ACT_READ);
    assign w_raddr = i_cmd.copy_step ? r_ptr[AW-1:0] : w_rd_addr;

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_waddr] <= w_wdata;
        if (w_re) r_rdata <= r_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_hold    <= 1'b0;
            r_arow    <= '0;
            r_ptr     <= '0;
            r_end     <= PW'(DEPTH);
            r_cp_pend <= 1'b0;
        end else begin
            r_col     <= n_col;
            r_row     <= n_row;
            r_hold    <= n_hold;
            r_arow    <= n_arow;
            r_cp_pend <= i_cmd.copy_step;
            priority if (i_cmd.copy_step || i_cmd.blank_step) begin
                r_ptr <= PW'(r_ptr + 1);
            end else if (i_cmd.bottom_load) begin
                r_ptr <= PW'((ROWS - 1) * COLS);
                r_end <= PW'(DEPTH);
            end else if (i_cmd.exec) begin
                if (i_cmd.act == tesc_pkg::ACT_ERASE_LINE) begin
                    r_ptr <= PW'(w_cur_addr);
                    r_end <= w_row_end;
                end else if (i_cmd.act == tesc_pkg::ACT_ERASE_SCREEN) begin
                    r_ptr <= PW'(w_cur_addr);
                    r_end <= PW'(DEPTH);
                end else if (i_cmd.act == tesc_pkg::ACT_LF) begin
                    // scroll reads start at the second row
                    r_ptr <= PW'(COLS);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.copy_step) r_cp_addr <= AW'(r_ptr - PW'(COLS));
        if (i_cmd.load) begin
            r_char <= i_char_in;
            r_rrow <= i_read_row;
            r_rcol <= i_read_col;
        end
        if (i_cmd.exec) begin
            r_in_range <= w_in_range;
            if (i_cmd.act != tesc_pkg::ACT_READ) r_cell <= '0;
        end
        if (i_cmd.read_take) begin
            r_cell <= r_in_range ? r_rdata : tesc_pkg::CH_SPACE;
        end
    end

    assign o_stat.blank_last = (PW'(r_ptr + 1) == r_end);
    assign o_stat.copy_last  = (r_ptr == PW'(DEPTH - 1));
    assign o_stat.at_bottom  = (r_row == LAST_ROW);

    assign o_cursor_col  = 7'(r_col);
    assign o_cursor_row  = 4'(r_row);
    assign o_hold_mode   = r_hold;
    assign o_reply_valid = i_cmd.reply_on;
    assign o_reply_byte  = i_cmd.reply_on ? tesc_pkg::reply_char(i_cmd.reply_idx) : '0;
    assign o_cell_char   = r_cell;
    assign o_last        = !i_cmd.reply_on || (i_cmd.reply_idx == tesc_pkg::REPLY_LAST);

    `TESC_ASSERT_IMP(a_cursor_in_screen, i_clk, i_rst_n, 1'b1, r_col <= LAST_COL && r_row <= LAST_ROW)
    `TESC_ASSERT_IMP(a_one_writer, i_clk, i_rst_n, r_cp_pend, !i_cmd.blank_step && !i_cmd.exec)

endmodule

// ===== rtl/terminal_escape_screen_engine.sv =====
// ----------------------------------------------------------------------------
// terminal_escape_screen_engine
// Character-cell terminal: escape decoding, cursor and ROWS x COLS screen.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_stall): one word is either a received
// character (i_op = 0, i_char_in) or a cell read (i_op = 1, i_read_row and
// i_read_col). Output channel (o_out_valid / i_out_stall): one result word per
// input word, three for the identify command (ESC, '/', 'H'); o_last marks the
// final word of each input.
// One word is in work at a time. A plain character, control or cursor command
// passes from accept through S_EXEC to S_RESULT, a cell read through S_EXEC,
// S_READ and S_RESULT; S_IDLE takes the next word once the result is taken.
// Erase to end of line or screen blanks one cell per cycle in S_BLANK. A line
// feed on the bottom row scrolls, copying (ROWS-1)*COLS cells one per cycle
// with reads and writes on separate store ports, passes the turnaround state
// S_TAIL, then blanks the COLS cells of the new row.
// After reset the store is swept to spaces, one cell a cycle, all ROWS*COLS
// cells (960 at 80x12); o_in_stall stays high until that pass ends.
// While i_out_stall is high the result word holds and no new input is taken.
// ----------------------------------------------------------------------------
module terminal_escape_screen_engine #(
    parameter int COLS = 80,
    parameter int ROWS = 12
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_op,
    input  logic [6:0] i_char_in,
    input  logic [3:0] i_read_row,
    input  logic [6:0] i_read_col,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [6:0] o_cursor_col,
    output logic [3:0] o_cursor_row,
    output logic       o_hold_mode,
    output logic       o_reply_valid,
    output logic [6:0] o_reply_byte,
    output logic [6:0] o_cell_char,
    output logic       o_last
);

    tesc_pkg::t_cmd  w_cmd;
    tesc_pkg::t_stat w_stat;

    tesc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_op        (i_op),
        .i_char_in   (i_char_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    tesc_dpath #(
        .COLS (COLS),
        .ROWS (ROWS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_char_in     (i_char_in),
        .i_read_row    (i_read_row),
        .i_read_col    (i_read_col),
        .o_cursor_col  (o_cursor_col),
        .o_cursor_row  (o_cursor_row),
        .o_hold_mode   (o_hold_mode),
        .o_reply_valid (o_reply_valid),
        .o_reply_byte  (o_reply_byte),
        .o_cell_char   (o_cell_char),
        .o_last        (o_last)
    );

endmodule
